### hdl/pidl_pkg.sv
// Shared types for the positional insert/delete list.
// Action and status codes, and the per-cell update select. No dependencies.
package pidl_pkg;

	typedef enum logic [2:0] {
		ACT_INS_FRONT = 3'd0,
		ACT_INS_BACK  = 3'd1,
		ACT_INS_POS   = 3'd2,
		ACT_DEL_FRONT = 3'd3,
		ACT_DEL_BACK  = 3'd4,
		ACT_DEL_POS   = 3'd5,
		ACT_DUMP      = 3'd6
	} act_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// What a cell loads on the next edge.
	typedef enum logic [2:0] {
		CELL_HOLD = 3'd0,
		CELL_LOAD = 3'd1,
		CELL_PREV = 3'd2,
		CELL_NEXT = 3'd3,
		CELL_HEAD = 3'd4
	} cell_op_t;

endpackage

### hdl/pidl_cell.sv
// One storage cell of the list chain: a 32-bit register fed from its
// neighbors, the head of the chain or a fresh value. Uses pidl_pkg.
module pidl_cell
	import pidl_pkg::*;
(
	input  logic        clk,
	input  cell_op_t    op,
	input  logic [31:0] fresh,
	input  logic [31:0] prev,
	input  logic [31:0] next,
	input  logic [31:0] head,
	output logic [31:0] data
);

	logic [31:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_LOAD: data_q <= fresh;
			CELL_PREV: data_q <= prev;
			CELL_NEXT: data_q <= next;
			CELL_HEAD: data_q <= head;
			default:   data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

### hdl/positional_insert_delete_list.sv
// Ordered list of up to DEPTH signed 32-bit words, held in a chain of cells
// where an insert opens a gap and a delete closes it in one shift of the
// chain. An insert or delete is accepted and gives one result word; the next
// item is taken in the following cycle as long as the result side is not
// stalled. A dump of n words is accepted, then gives one word per cycle while
// the result side is not stalled, read from the front cell while the chain
// rotates by one, so after the dump the list is back in its original order.
// Positions are 1-based. Count shows the occupancy masked to 6 bits. Uses
// pidl_pkg and pidl_cell.
module positional_insert_delete_list
	import pidl_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         action,
	input  logic signed [31:0] value,
	input  logic [5:0]         position,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         status,
	output logic signed [31:0] element,
	output logic [5:0]         count,
	output logic               last
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = ((CW > 6) ? CW : 6) + 1;

	logic [CW-1:0]  occ_q;
	logic [CW-1:0]  rem_q;
	logic           dumping_q;
	logic           rsp_valid_q;
	status_t        stat_q;
	logic [31:0]    elem_q;
	logic [5:0]     count_q;
	logic           last_q;

	logic [31:0]    cell_data [DEPTH];
	logic           take;
	logic           ins_go;
	logic           del_go;
	logic           rot_go;
	logic           dump_start;
	logic           emit_c;
	logic           last_c;
	status_t        st_c;
	logic [31:0]    elem_c;
	logic [CW-1:0]  occ_c;
	logic [AW-1:0]  idx_c;
	logic [AW-1:0]  n_x;
	logic [AW-1:0]  pos_x;
	logic [31:0]    pick;
	act_t           act;

	assign req_stall = dumping_q || (rsp_valid_q && rsp_stall);
	assign take      = req_valid && !req_stall;
	assign n_x       = AW'(occ_q);
	assign pos_x     = AW'(position);
	assign act       = act_t'(action);

	// word sitting at idx_c, for deletes
	always_comb begin
		pick = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (AW'(i) == idx_c) begin
				pick = pick | cell_data[i];
			end
		end
	end

	always_comb begin
		ins_go     = 1'b0;
		del_go     = 1'b0;
		rot_go     = 1'b0;
		dump_start = 1'b0;
		emit_c     = 1'b0;
		last_c     = 1'b1;
		st_c       = ST_OK;
		elem_c     = '0;
		occ_c      = occ_q;
		idx_c      = '0;
		if (take) begin
			case (act)
				ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
					emit_c = 1'b1;
					if (act == ACT_INS_BACK) begin
						idx_c = n_x;
					end else if (act == ACT_INS_POS) begin
						idx_c = pos_x - AW'(1);
					end
					if (act == ACT_INS_POS && (pos_x == '0 || pos_x > n_x + AW'(1))) begin
						st_c = ST_BADPOS;
					end else if (occ_q == CW'(DEPTH)) begin
						st_c = ST_FULL;
					end else begin
						ins_go = 1'b1;
						occ_c  = occ_q + CW'(1);
					end
				end
				ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_POS: begin
					emit_c = 1'b1;
					if (act == ACT_DEL_BACK) begin
						idx_c = n_x - AW'(1);
					end else if (act == ACT_DEL_POS) begin
						idx_c = pos_x - AW'(1);
					end
					if (occ_q == '0) begin
						st_c = ST_EMPTY;
					end else if (act == ACT_DEL_POS && (pos_x == '0 || pos_x > n_x)) begin
						st_c = ST_BADPOS;
					end else begin
						del_go = 1'b1;
						elem_c = pick;
						occ_c  = occ_q - CW'(1);
					end
				end
				ACT_DUMP: begin
					if (occ_q == '0) begin
						emit_c = 1'b1;
						st_c   = ST_EMPTY;
					end else begin
						dump_start = 1'b1;
					end
				end
				default: begin
					emit_c = 1'b1;
				end
			endcase
		end else if (dumping_q && !(rsp_valid_q && rsp_stall)) begin
			rot_go = 1'b1;
			emit_c = 1'b1;
			elem_c = cell_data[0];
			last_c = (rem_q == CW'(1));
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		localparam logic [AW-1:0] GI = AW'(g);
		cell_op_t    op;
		logic [31:0] prev_w;
		logic [31:0] next_w;

		if (g == 0) begin : g_first
			assign prev_w = '0;
		end else begin : g_mid
			assign prev_w = cell_data[g-1];
		end
		if (g == DEPTH - 1) begin : g_tail
			assign next_w = '0;
		end else begin : g_body
			assign next_w = cell_data[g+1];
		end

		always_comb begin
			op = CELL_HOLD;
			if (ins_go) begin
				if (GI == idx_c) begin
					op = CELL_LOAD;
				end else if (GI > idx_c && GI <= n_x) begin
					op = CELL_PREV;
				end
			end else if (del_go) begin
				if (GI >= idx_c && (GI + AW'(1)) < n_x) begin
					op = CELL_NEXT;
				end
			end else if (rot_go) begin
				if ((GI + AW'(1)) < n_x) begin
					op = CELL_NEXT;
				end else if ((GI + AW'(1)) == n_x) begin
					op = CELL_HEAD;
				end
			end
		end

		pidl_cell u_cell (
			.clk   (clk),
			.op    (op),
			.fresh (value),
			.prev  (prev_w),
			.next  (next_w),
			.head  (cell_data[0]),
			.data  (cell_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			rem_q       <= '0;
			dumping_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			occ_q <= occ_c;
			if (dump_start) begin
				dumping_q <= 1'b1;
				rem_q     <= occ_q;
			end else if (rot_go) begin
				rem_q <= rem_q - CW'(1);
				if (rem_q == CW'(1)) begin
					dumping_q <= 1'b0;
				end
			end
			if (emit_c) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (emit_c) begin
			stat_q  <= st_c;
			elem_q  <= elem_c;
			count_q <= 6'(occ_c);
			last_q  <= last_c;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = stat_q;
	assign element   = elem_q;
	assign count     = count_q;
	assign last      = last_q;

endmodule

### tb/tb.sv
// Self-checking testbench for positional_insert_delete_list.
// Holds a queue-based copy of the list, compares every result word in order.
// Depends on pidl_pkg and the list RTL.
module tb
	import pidl_pkg::*;
;

	localparam int LIST_DEPTH = 32;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
	localparam int HOLD_CYCLES = 250;
	localparam int MAX_REPORTS = 10;
	localparam logic [2:0] ACT_SPARE = 3'd7;

	typedef struct packed {
		logic [1:0]         st;
		logic signed [31:0] elem;
		logic [5:0]         cnt;
		logic               lst;
	} list_result_t;

	class list_scoreboard;
		logic signed [31:0] cells[$];
		list_result_t       want_q[$];
		int                 errors;

		function new();
			errors = 0;
		endfunction

		function void push_result(logic [1:0] st, logic signed [31:0] elem, logic lst);
			list_result_t r;
			r.st   = st;
			r.elem = elem;
			r.cnt  = 6'(cells.size());
			r.lst  = lst;
			want_q.push_back(r);
		endfunction

		// Apply one accepted input word to the list copy and queue its results.
		function void note_word(logic [2:0] a, logic signed [31:0] v, logic [5:0] p);
			int n;
			int pi;
			int idx;
			logic signed [31:0] gone;
			n  = cells.size();
			pi = int'(p);
			case (a)
				ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
					// position check wins over the full check
					if (a == ACT_INS_POS && (pi < 1 || pi > n + 1)) begin
						push_result(ST_BADPOS, '0, 1'b1);
					end else if (n >= LIST_DEPTH) begin
						push_result(ST_FULL, '0, 1'b1);
					end else begin
						if (a == ACT_INS_FRONT)
							idx = 0;
						else if (a == ACT_INS_BACK)
							idx = n;
						else
							idx = pi - 1;
						cells.insert(idx, v);
						push_result(ST_OK, '0, 1'b1);
					end
				end
				ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_POS: begin
					// empty check wins over the position check
					if (n == 0) begin
						push_result(ST_EMPTY, '0, 1'b1);
					end else if (a == ACT_DEL_POS && (pi < 1 || pi > n)) begin
						push_result(ST_BADPOS, '0, 1'b1);
					end else begin
						if (a == ACT_DEL_FRONT)
							idx = 0;
						else if (a == ACT_DEL_BACK)
							idx = n - 1;
						else
							idx = pi - 1;
						gone = cells[idx];
						cells.delete(idx);
						push_result(ST_OK, gone, 1'b1);
					end
				end
				ACT_DUMP: begin
					if (n == 0) begin
						push_result(ST_EMPTY, '0, 1'b1);
					end else begin
						for (int i = 0; i < n; i++)
							push_result(ST_OK, cells[i], i == n - 1);
					end
				end
				default: begin
					push_result(ST_OK, '0, 1'b1);
				end
			endcase
		endfunction

		function void check_word(logic [1:0] st, logic signed [31:0] elem, logic [5:0] cnt,
				logic lst);
			list_result_t got;
			list_result_t want;
			got.st   = st;
			got.elem = elem;
			got.cnt  = cnt;
			got.lst  = lst;
			if (want_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected word: status %0d element %0d count %0d last %0d",
						st, elem, cnt, lst);
				return;
			end
			want = want_q.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display({"word mismatch: exp st %0d el %0d cnt %0d last %0d,",
						" got st %0d el %0d cnt %0d last %0d"},
						want.st, want.elem, want.cnt, want.lst, st, elem, cnt, lst);
			end
		endfunction

		function int pending();
			return want_q.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic [2:0]         action;
	logic signed [31:0] value;
	logic [5:0]         position;
	logic               rsp_valid;
	logic               rsp_stall;
	logic [1:0]         status;
	logic signed [31:0] element;
	logic [5:0]         count;
	logic               last;

	list_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	bit pressure_on;
	int hold_left = HOLD_CYCLES;
	int cycles;

	positional_insert_delete_list #(.DEPTH(LIST_DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.action    (action),
		.value     (value),
		.position  (position),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.element   (element),
		.count     (count),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result side: random stall, plus one long hold-off once pressure is on.
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_on && hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Note accepted input first, then check the result word of the same edge.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_word(action, value, position);
			if (rsp_valid && !rsp_stall)
				sb.check_word(status, element, count, last);
		end
	end

	// Called and returns at a falling edge; valid stays high into the next word.
	task automatic send_word(input logic [2:0] a, input logic signed [31:0] v,
			input logic [5:0] p);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		action    <= a;
		value     <= v;
		position  <= p;
		do
			@(posedge clk);
		while (!(req_valid && !req_stall));
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			default: return $urandom;
		endcase
	endfunction

	// Mostly well-formed positions; drifts between growing and shrinking the list.
	task automatic random_words(input int n);
		int done;
		int occ;
		int pick;
		int grow;
		logic [2:0] a;
		logic [5:0] p;
		done = 0;
		grow = 1;
		while (done < n) begin
			if (done % 24 == 0)
				grow = $urandom_range(1);
			occ  = sb.cells.size();
			pick = $urandom_range(99);
			if (pick < 3) begin
				a = ACT_SPARE;
			end else if (pick < 12) begin
				a = ACT_DUMP;
			end else if (pick < (grow ? 68 : 38)) begin
				case ($urandom_range(2))
					0: a = ACT_INS_FRONT;
					1: a = ACT_INS_BACK;
					default: a = ACT_INS_POS;
				endcase
			end else begin
				case ($urandom_range(2))
					0: a = ACT_DEL_FRONT;
					1: a = ACT_DEL_BACK;
					default: a = ACT_DEL_POS;
				endcase
			end
			if ($urandom_range(9) == 0)
				p = 6'($urandom_range(63));
			else if (a == ACT_INS_POS || a == ACT_INS_FRONT || a == ACT_INS_BACK)
				p = 6'($urandom_range(1, occ + 1));
			else if (occ > 0)
				p = 6'($urandom_range(1, occ));
			else
				p = 6'($urandom_range(63));
			send_word(a, pick_value(), p);
			if (a != ACT_SPARE)
				done++;
		end
	endtask

	initial begin
		sb        = new();
		cycles    = 0;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		action    = ACT_DUMP;
		value     = '0;
		position  = '0;
		pressure_on   = 1'b0;
		send_idle_pct = 33;
		recv_idle_pct = 85;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty list, bad positions, extremes, every action
		send_word(ACT_DUMP,      '0, 6'd0);
		send_word(ACT_DEL_FRONT, '0, 6'd0);
		send_word(ACT_DEL_BACK,  '0, 6'd0);
		send_word(ACT_DEL_POS,   '0, 6'd0);   // empty reported, not bad position
		send_word(ACT_INS_POS,   32'sd5, 6'd0);
		send_word(ACT_INS_POS,   32'sd5, 6'd2);
		send_word(ACT_INS_FRONT, 32'sh7fffffff, 6'd63);
		send_word(ACT_INS_BACK,  32'sh80000000, 6'd0);
		send_word(ACT_INS_POS,   -32'sd1, 6'd1);
		send_word(ACT_INS_POS,   32'sh55555555, 6'd4);
		send_word(ACT_INS_POS,   32'shaaaaaaaa, 6'd63);
		send_word(ACT_INS_POS,   '0, 6'd2);
		send_word(ACT_DUMP,      '0, 6'd0);
		send_word(ACT_DEL_POS,   '0, 6'd0);
		send_word(ACT_DEL_POS,   '0, 6'd6);
		send_word(ACT_DEL_POS,   '0, 6'd5);
		send_word(ACT_DEL_POS,   '0, 6'd2);
		send_word(ACT_SPARE,     32'sh12345678, 6'd42);
		send_word(ACT_DEL_FRONT, '0, 6'd0);
		send_word(ACT_DEL_BACK,  '0, 6'd0);
		send_word(ACT_DUMP,      '0, 6'd0);
		send_word(ACT_DEL_BACK,  '0, 6'd0);
		send_word(ACT_DUMP,      '0, 6'd0);

		random_words(65);

		send_idle_pct = 85;
		recv_idle_pct = 33;
		random_words(65);

		// no idling; hold the result side off while filling the list to full
		send_idle_pct = 0;
		recv_idle_pct = 0;
		pressure_on   = 1'b1;
		for (int k = 0; k < LIST_DEPTH + 4; k++)
			send_word(ACT_INS_BACK, pick_value(), 6'd0);
		send_word(ACT_INS_POS,   32'sd9, 6'd5);    // full
		send_word(ACT_INS_POS,   32'sd9, 6'd40);   // bad position wins
		send_word(ACT_INS_FRONT, 32'sd9, 6'd0);
		send_word(ACT_DUMP,      '0, 6'd0);
		send_word(ACT_DEL_POS,   '0, 6'd32);
		send_word(ACT_DEL_POS,   '0, 6'd33);
		random_words(65);

		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/pidl_pkg.sv
hdl/pidl_cell.sv
hdl/positional_insert_delete_list.sv
tb/tb.sv
